### sv/vfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg
// shared types, widths and codes of the voxel face cull update core
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int MAX_DIM   = 32;
    localparam int MAX_CELLS = 32768;

    localparam int CRD_W  = 5;
    localparam int DIM_W  = 6;
    localparam int KIND_W = 2;
    localparam int CMD_W  = 3;
    localparam int FACE_W = 3;
    localparam int NDIR   = 6;
    localparam int WH_W   = 2 * DIM_W;
    localparam int CALC_W = WH_W + CRD_W + 1;
    localparam int AW     = $clog2(MAX_CELLS);
    localparam int CIDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HIDE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHOW   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REJECT = 3'd4;

    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_AIR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STONE = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DEPTH  = 2'd2;

    typedef struct packed {
        logic              mul;
        logic              base;
        logic [FACE_W-1:0] dir;
    } t_agu_ctl;

endpackage

### sv/voxel_face_cull_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_cull_update_core
// place and remove requests on a voxel grid, emitting mesh update commands
//
//  port group      dir  fields (low bit first)
//  s_axis_*        in   tuser: func | tdata: pos_x, pos_y, pos_z, voxel_kind
//  m_axis_*        out  tuser: command | tdata: target x, y, z, face | tlast
//  i_cfg_*         in   write enable, register index, 6-bit size value
//
//  the single store port is read once per neighbour (not at all for a reject),
//  and results leave one per cycle while the output is not stalled
//  after reset all 32768 cells of the store are swept to air, no transfer taken
//  a stalled output holds the sequencer; the next request is taken while the
//  final result still waits in the output register
// ----------------------------------------------------------------------------
module voxel_face_cull_update_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // pos_x, pos_y, pos_z, voxel_kind
    input  logic [0:0]                    s_axis_tuser,   // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // target_x, target_y, target_z, face
    output logic [vfc_pkg::CMD_W-1:0]     m_axis_tuser,   // command
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [vfc_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [vfc_pkg::DIM_W-1:0]     i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_BASE  = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_RDW   = 10'b0000010000,
        S_WR    = 10'b0000100000,
        S_FIRST = 10'b0001000000,
        S_ADD   = 10'b0010000000,
        S_NB    = 10'b0100000000,
        S_TAIL  = 10'b1000000000
    } t_state;

    localparam int CW = vfc_pkg::CRD_W;
    localparam int DW = vfc_pkg::DIM_W;
    localparam int FW = vfc_pkg::FACE_W;
    localparam int KW = vfc_pkg::KIND_W;

    function automatic logic [FW-1:0] low_bit(input logic [vfc_pkg::NDIR-1:0] m);
        logic [FW-1:0] r;
        r = '0;
        for (int i = vfc_pkg::NDIR - 1; i >= 0; i--) begin
            if (m[i]) r = FW'(i);
        end
        return r;
    endfunction

    t_state                    r_state, n_state;
    logic [DW-1:0]             r_cfg_w, r_cfg_h, r_cfg_d;
    logic [DW-1:0]             weff, heff, deff;
    logic                      r_func;
    logic [CW-1:0]             r_x, r_y, r_z;
    logic [KW-1:0]             r_kind;
    logic [FW-1:0]             r_dir;
    logic                      r_rd_pend;
    logic [FW-1:0]             r_rd_dir;
    logic [vfc_pkg::NDIR-1:0]  r_mask, n_mask;
    logic                      r_half, n_half;
    logic [vfc_pkg::NDIR-1:0]  nb_inb;
    logic                      in_grid;
    logic                      s_take;
    logic                      o_free;
    logic                      busy;
    logic [KW-1:0]             rd_data;
    logic [vfc_pkg::AW-1:0]    center, nb_addr;
    vfc_pkg::t_agu_ctl         agu_ctl;
    logic [FW-1:0]             d;
    logic [vfc_pkg::NDIR-1:0]  rest;
    logic [CW-1:0]             nx, ny, nz;
    logic                      emit;
    logic [vfc_pkg::CMD_W-1:0] e_cmd;
    logic [CW-1:0]             e_x, e_y, e_z;
    logic [FW-1:0]             e_face;
    logic                      e_last;
    logic                      r_ovalid;
    logic [vfc_pkg::CMD_W-1:0] r_ocmd;
    logic [CW-1:0]             r_ox, r_oy, r_oz;
    logic [FW-1:0]             r_oface;
    logic                      r_olast;

    // effective sizes saturate at the grid maximum
    assign weff = (r_cfg_w > DW'(vfc_pkg::MAX_DIM)) ? DW'(vfc_pkg::MAX_DIM) : r_cfg_w;
    assign heff = (r_cfg_h > DW'(vfc_pkg::MAX_DIM)) ? DW'(vfc_pkg::MAX_DIM) : r_cfg_h;
    assign deff = (r_cfg_d > DW'(vfc_pkg::MAX_DIM)) ? DW'(vfc_pkg::MAX_DIM) : r_cfg_d;

    assign in_grid = ({1'b0, r_x} < weff) && ({1'b0, r_y} < heff) && ({1'b0, r_z} < deff);

    assign nb_inb[vfc_pkg::FACE_RIGHT]  = ({1'b0, r_x} + DW'(1)) < weff;
    assign nb_inb[vfc_pkg::FACE_LEFT]   = (r_x != '0);
    assign nb_inb[vfc_pkg::FACE_TOP]    = ({1'b0, r_y} + DW'(1)) < heff;
    assign nb_inb[vfc_pkg::FACE_BOTTOM] = (r_y != '0);
    assign nb_inb[vfc_pkg::FACE_FRONT]  = ({1'b0, r_z} + DW'(1)) < deff;
    assign nb_inb[vfc_pkg::FACE_BACK]   = (r_z != '0);

    assign s_axis_tready = (r_state == S_IDLE) && !busy;
    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign o_free        = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DW'(32);
            r_cfg_h <= DW'(32);
            r_cfg_d <= DW'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vfc_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                vfc_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                vfc_pkg::CFG_DEPTH:  r_cfg_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign agu_ctl.mul  = (r_state == S_MUL);
    assign agu_ctl.base = (r_state == S_BASE);
    assign agu_ctl.dir  = r_dir;

    vfc_agu u_agu (
        .i_clk     (i_clk),
        .i_ctl     (agu_ctl),
        .i_weff    (weff),
        .i_heff    (heff),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_z       (r_z),
        .o_center  (center),
        .o_nb_addr (nb_addr)
    );

    vfc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == S_RD),
        .i_rd_addr (nb_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_WR),
        .i_wr_addr (center),
        .i_wr_data (r_func ? vfc_pkg::KIND_AIR : r_kind),
        .o_busy    (busy)
    );

    // next solid neighbour and its coordinates
    assign d    = low_bit(r_mask);
    assign rest = r_mask & ~(vfc_pkg::NDIR'(1) << d);

    always_comb begin
        nx = r_x;
        ny = r_y;
        nz = r_z;
        case (d)
            vfc_pkg::FACE_RIGHT:  nx = r_x + CW'(1);
            vfc_pkg::FACE_LEFT:   nx = r_x - CW'(1);
            vfc_pkg::FACE_TOP:    ny = r_y + CW'(1);
            vfc_pkg::FACE_BOTTOM: ny = r_y - CW'(1);
            vfc_pkg::FACE_FRONT:  nz = r_z + CW'(1);
            default:              nz = r_z - CW'(1);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        n_half  = r_half;
        emit    = 1'b0;
        e_cmd   = vfc_pkg::CMD_REMOVE;
        e_x     = r_x;
        e_y     = r_y;
        e_z     = r_z;
        e_face  = vfc_pkg::FACE_RIGHT;
        e_last  = 1'b0;
        if (r_rd_pend) begin
            n_mask[r_rd_dir] = nb_inb[r_rd_dir] && (rd_data != vfc_pkg::KIND_AIR);
        end
        case (r_state)
            S_IDLE: begin
                if (s_take) begin
                    n_state = S_MUL;
                    n_mask  = '0;
                    n_half  = 1'b0;
                end
            end
            S_MUL:  n_state = in_grid ? S_BASE : S_FIRST;
            S_BASE: n_state = S_RD;
            S_RD: begin
                if (r_dir == FW'(vfc_pkg::NDIR - 1)) n_state = S_RDW;
            end
            S_RDW:  n_state = S_WR;
            S_WR:   n_state = S_FIRST;
            S_FIRST: begin
                if (o_free) begin
                    emit = 1'b1;
                    if (!in_grid) begin
                        e_cmd   = vfc_pkg::CMD_REJECT;
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_func) begin
                        n_state = (r_mask != '0) ? S_NB : S_TAIL;
                    end else if (r_kind == vfc_pkg::KIND_AIR) begin
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                if (o_free) begin
                    emit    = 1'b1;
                    e_cmd   = vfc_pkg::CMD_ADD;
                    e_last  = (r_mask == '0);
                    n_state = (r_mask != '0) ? S_NB : S_IDLE;
                end
            end
            S_NB: begin
                if (o_free) begin
                    emit = 1'b1;
                    if (r_func) begin
                        e_cmd   = vfc_pkg::CMD_SHOW;
                        e_x     = nx;
                        e_y     = ny;
                        e_z     = nz;
                        e_face  = d ^ FW'(1);
                        n_mask  = rest;
                        n_state = (rest != '0) ? S_NB : S_TAIL;
                    end else if (!r_half) begin
                        e_cmd  = vfc_pkg::CMD_HIDE;
                        e_face = d;
                        n_half = 1'b1;
                    end else begin
                        e_cmd   = vfc_pkg::CMD_HIDE;
                        e_x     = nx;
                        e_y     = ny;
                        e_z     = nz;
                        e_face  = d ^ FW'(1);
                        e_last  = (rest == '0);
                        n_half  = 1'b0;
                        n_mask  = rest;
                        n_state = (rest != '0) ? S_NB : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (o_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_dir     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_RD);
            if (r_state == S_RD) begin
                r_dir <= r_dir + FW'(1);
            end else begin
                r_dir <= '0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask   <= n_mask;
        r_half   <= n_half;
        r_rd_dir <= r_dir;
        if (s_take) begin
            r_func <= s_axis_tuser[0];
            r_x    <= s_axis_tdata[4:0];
            r_y    <= s_axis_tdata[9:5];
            r_z    <= s_axis_tdata[14:10];
            r_kind <= (s_axis_tdata[16:15] > vfc_pkg::KIND_STONE) ? vfc_pkg::KIND_STONE
                                                                  : s_axis_tdata[16:15];
        end
        if (emit) begin
            r_ocmd  <= e_cmd;
            r_ox    <= e_x;
            r_oy    <= e_y;
            r_oz    <= e_z;
            r_oface <= e_face;
            r_olast <= e_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ocmd;
    assign m_axis_tdata  = {6'b0, r_oface, r_oz, r_oy, r_ox};
    assign m_axis_tlast  = r_olast;

endmodule

### sv/vfc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_store
// voxel kind memory with a clearing sweep to air after reset
// ----------------------------------------------------------------------------
module vfc_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [vfc_pkg::AW-1:0]    i_rd_addr,
    output logic [vfc_pkg::KIND_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [vfc_pkg::AW-1:0]    i_wr_addr,
    input  logic [vfc_pkg::KIND_W-1:0] i_wr_data,
    output logic                      o_busy
);

    logic [vfc_pkg::KIND_W-1:0] r_mem [vfc_pkg::MAX_CELLS];
    logic                       r_clr_busy;
    logic [vfc_pkg::AW-1:0]     r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + vfc_pkg::AW'(1);
            if (r_clr_cnt == vfc_pkg::AW'(vfc_pkg::MAX_CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_cnt] <= vfc_pkg::KIND_AIR;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy = r_clr_busy;

endmodule

### sv/vfc_agu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_agu
// cell index unit: linear index of the cell and one neighbour offset per cycle
// ----------------------------------------------------------------------------
module vfc_agu (
    input  logic                      i_clk,
    input  vfc_pkg::t_agu_ctl         i_ctl,
    input  logic [vfc_pkg::DIM_W-1:0] i_weff,
    input  logic [vfc_pkg::DIM_W-1:0] i_heff,
    input  logic [vfc_pkg::CRD_W-1:0] i_x,
    input  logic [vfc_pkg::CRD_W-1:0] i_y,
    input  logic [vfc_pkg::CRD_W-1:0] i_z,
    output logic [vfc_pkg::AW-1:0]    o_center,
    output logic [vfc_pkg::AW-1:0]    o_nb_addr
);

    logic [vfc_pkg::WH_W-1:0]   r_wh;
    logic [vfc_pkg::WH_W-1:0]   r_yw;
    logic [vfc_pkg::CALC_W-1:0] r_base;
    logic [vfc_pkg::WH_W-1:0]   delta;
    logic [vfc_pkg::CALC_W-1:0] sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_wh <= vfc_pkg::WH_W'(i_weff) * vfc_pkg::WH_W'(i_heff);
            r_yw <= vfc_pkg::WH_W'(i_y) * vfc_pkg::WH_W'(i_weff);
        end
        if (i_ctl.base) begin
            r_base <= vfc_pkg::CALC_W'(i_x) + vfc_pkg::CALC_W'(r_yw)
                    + vfc_pkg::CALC_W'(i_z) * vfc_pkg::CALC_W'(r_wh);
        end
    end

    always_comb begin
        case (i_ctl.dir)
            vfc_pkg::FACE_RIGHT, vfc_pkg::FACE_LEFT: delta = vfc_pkg::WH_W'(1);
            vfc_pkg::FACE_TOP, vfc_pkg::FACE_BOTTOM: delta = vfc_pkg::WH_W'(i_weff);
            default:                                 delta = r_wh;
        endcase
        if (i_ctl.dir[0]) begin
            sum = r_base - vfc_pkg::CALC_W'(delta);
        end else begin
            sum = r_base + vfc_pkg::CALC_W'(delta);
        end
    end

    assign o_nb_addr = sum[vfc_pkg::AW-1:0];
    assign o_center  = r_base[vfc_pkg::AW-1:0];

endmodule
